// ----- rtl/kalman_tilt_estimator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Kalman tilt estimator assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KALMAN_TILT_ESTIMATOR_UNIT_ASSERT_SVH
`define KALMAN_TILT_ESTIMATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk_i, held off during reset.
`define KTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, held off during reset.
`define KTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KTE_ASSERT_NOW(lbl, ante, cons, msg)
`define KTE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/kte_pkg.sv -----
// ----------------------------------------------------------------------------
// Kalman tilt estimator package
// Shared constants, codes, micro-operation program and status types.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int FRAC_BITS_DEF  = 32;
  localparam int WORD_BITS_DEF  = 48;
  localparam int LIMB_BITS      = 32;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_INDEX_BITS = 3;
  localparam int STEP_BITS      = 6;

  localparam int TS_BITS = 33;
  localparam int QA_BITS = 47;
  localparam int QC_BITS = 48;
  localparam int QR_BITS = 47;
  localparam int MN_BITS = 47;

  localparam logic [TS_BITS-1:0] TS_RESET = 33'd42949673;
  localparam logic [QA_BITS-1:0] QA_RESET = 47'd1074;
  localparam logic [QC_BITS-1:0] QC_RESET = 48'd214748;
  localparam logic [QR_BITS-1:0] QR_RESET = 47'd42949673;
  localparam logic [MN_BITS-1:0] MN_RESET = 47'd42949673;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TIME_STEP  = 3'd0,
    CFG_Q_ANGLE    = 3'd1,
    CFG_Q_CROSS    = 3'd2,
    CFG_Q_RATE     = 3'd3,
    CFG_MEAS_NOISE = 3'd4
  } kte_cfg_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } kte_op_e;

  typedef enum logic [4:0] {
    R_DT, R_Q00, R_Q01, R_Q11, R_R,
    R_GP, R_GR, R_AP, R_AR,
    R_ANG0, R_ANG1, R_RT0, R_RT1,
    R_P00, R_P01, R_P10, R_P11,
    R_B, R_S, R_K0, R_K1, R_T, R_Y
  } kte_opd_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_RUN, ST_WAIT, ST_DONE
  } kte_state_e;

  typedef struct packed {
    kte_op_e  op;
    kte_opd_e a;
    kte_opd_e b;
    kte_opd_e dst;
  } kte_uop_t;

  typedef struct packed {
    logic done;
    logic sat;
  } kte_unit_st_t;

  localparam logic [STEP_BITS-1:0] LAST_STEP = 6'd40;

  function automatic kte_uop_t mk(kte_op_e op, kte_opd_e a, kte_opd_e b, kte_opd_e d);
    kte_uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = d;
    return u;
  endfunction

  // One predict and correct step as a straight-line program.
  function automatic kte_uop_t uop_at(logic [STEP_BITS-1:0] s);
    kte_uop_t u;
    case (s)
      6'd0:  u = mk(OP_MUL, R_DT,   R_RT0, R_T);
      6'd1:  u = mk(OP_ADD, R_ANG0, R_T,   R_ANG0);
      6'd2:  u = mk(OP_MUL, R_DT,   R_GP,  R_T);
      6'd3:  u = mk(OP_ADD, R_RT0,  R_T,   R_RT0);
      6'd4:  u = mk(OP_MUL, R_DT,   R_RT1, R_T);
      6'd5:  u = mk(OP_ADD, R_ANG1, R_T,   R_ANG1);
      6'd6:  u = mk(OP_MUL, R_DT,   R_GR,  R_T);
      6'd7:  u = mk(OP_ADD, R_RT1,  R_T,   R_RT1);
      6'd8:  u = mk(OP_MUL, R_DT,   R_P11, R_T);
      6'd9:  u = mk(OP_ADD, R_P01,  R_T,   R_B);
      6'd10: u = mk(OP_MUL, R_DT,   R_P10, R_T);
      6'd11: u = mk(OP_ADD, R_P00,  R_T,   R_P00);
      6'd12: u = mk(OP_MUL, R_DT,   R_B,   R_T);
      6'd13: u = mk(OP_ADD, R_P00,  R_T,   R_P00);
      6'd14: u = mk(OP_ADD, R_P00,  R_Q00, R_P00);
      6'd15: u = mk(OP_ADD, R_B,    R_Q01, R_P01);
      6'd16: u = mk(OP_MUL, R_DT,   R_P11, R_T);
      6'd17: u = mk(OP_ADD, R_P10,  R_T,   R_P10);
      6'd18: u = mk(OP_ADD, R_P10,  R_Q01, R_P10);
      6'd19: u = mk(OP_ADD, R_P11,  R_Q11, R_P11);
      6'd20: u = mk(OP_ADD, R_P00,  R_R,   R_S);
      6'd21: u = mk(OP_DIV, R_P00,  R_S,   R_K0);
      6'd22: u = mk(OP_DIV, R_P10,  R_S,   R_K1);
      6'd23: u = mk(OP_SUB, R_AP,   R_ANG0, R_Y);
      6'd24: u = mk(OP_MUL, R_K0,   R_Y,   R_T);
      6'd25: u = mk(OP_ADD, R_ANG0, R_T,   R_ANG0);
      6'd26: u = mk(OP_MUL, R_K1,   R_Y,   R_T);
      6'd27: u = mk(OP_ADD, R_RT0,  R_T,   R_RT0);
      6'd28: u = mk(OP_SUB, R_AR,   R_ANG1, R_Y);
      6'd29: u = mk(OP_MUL, R_K0,   R_Y,   R_T);
      6'd30: u = mk(OP_ADD, R_ANG1, R_T,   R_ANG1);
      6'd31: u = mk(OP_MUL, R_K1,   R_Y,   R_T);
      6'd32: u = mk(OP_ADD, R_RT1,  R_T,   R_RT1);
      6'd33: u = mk(OP_MUL, R_K1,   R_P00, R_T);
      6'd34: u = mk(OP_SUB, R_P10,  R_T,   R_P10);
      6'd35: u = mk(OP_MUL, R_K1,   R_P01, R_T);
      6'd36: u = mk(OP_SUB, R_P11,  R_T,   R_P11);
      6'd37: u = mk(OP_MUL, R_K0,   R_P00, R_T);
      6'd38: u = mk(OP_SUB, R_P00,  R_T,   R_P00);
      6'd39: u = mk(OP_MUL, R_K0,   R_P01, R_T);
      6'd40: u = mk(OP_SUB, R_P01,  R_T,   R_P01);
      default: u = mk(OP_ADD, R_T, R_T, R_T);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/kte_mul.sv -----
// ----------------------------------------------------------------------------
// Kalman tilt estimator multiplier
// Fixed-point product over 32x32 limb partials, rounded and saturated.
// ----------------------------------------------------------------------------
module kte_mul #(
  parameter int WORD_BITS = kte_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = kte_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic signed [WORD_BITS-1:0] res_o,
  output kte_pkg::kte_unit_st_t       st_o
);
  import kte_pkg::*;

  localparam int NL = (WORD_BITS + LIMB_BITS - 1) / LIMB_BITS;
  localparam int MB = NL * LIMB_BITS;
  localparam int PB = 2 * MB;
  localparam int IB = (NL > 1) ? $clog2(NL) : 1;
  localparam int RB = 2 * WORD_BITS + 1;
  localparam logic [RB-1:0] LIM_NEG = RB'(1) << (WORD_BITS - 1);
  localparam logic [RB-1:0] LIM_POS = LIM_NEG - RB'(1);
  localparam logic [RB-1:0] HALF    = RB'(1) << (FRAC_BITS - 1);
  localparam logic [IB-1:0] LAST_L  = IB'(NL - 1);

  logic            busy_q, issued_q, ppv_q, neg_q;
  logic [MB-1:0]   ma_q, mb_q;
  logic [IB-1:0]   i_q, j_q;
  logic [IB:0]     sh_q;
  logic [2*LIMB_BITS-1:0] pp_q;
  logic [PB-1:0]   acc_q;
  logic [WORD_BITS-1:0] ua, ub;
  logic [RB-1:0]   rnd, quo, lim;
  logic            over;
  logic [WORD_BITS-1:0] qlo;

  assign ua = a_i[WORD_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign ub = b_i[WORD_BITS-1] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      issued_q <= 1'b0;
      ppv_q    <= 1'b0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      issued_q <= 1'b0;
      ppv_q    <= 1'b0;
    end else if (busy_q) begin
      ppv_q <= !issued_q;
      if (!issued_q && i_q == LAST_L && j_q == LAST_L) begin
        issued_q <= 1'b1;
      end
      if (issued_q && !ppv_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= MB'(ua);
      mb_q  <= MB'(ub);
      neg_q <= a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
      i_q   <= '0;
      j_q   <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      if (!issued_q) begin
        pp_q <= ma_q[i_q*LIMB_BITS +: LIMB_BITS] * mb_q[j_q*LIMB_BITS +: LIMB_BITS];
        sh_q <= (IB+1)'(i_q) + (IB+1)'(j_q);
        if (j_q == LAST_L) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (ppv_q) begin
        acc_q <= acc_q + (PB'(pp_q) << (sh_q * LIMB_BITS));
      end
    end
  end

  // Round to nearest, ties away from zero, then saturate on magnitude.
  assign rnd  = {1'b0, acc_q[2*WORD_BITS-1:0]} + HALF;
  assign quo  = rnd >> FRAC_BITS;
  assign lim  = neg_q ? LIM_NEG : LIM_POS;
  assign over = quo > lim;
  assign qlo  = quo[WORD_BITS-1:0];

  always_comb begin
    if (over) begin
      res_o = neg_q ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else begin
      res_o = neg_q ? (~qlo + 1'b1) : qlo;
    end
  end

  assign st_o.done = busy_q && issued_q && !ppv_q;
  assign st_o.sat  = over;

endmodule

// ----- rtl/kte_div.sv -----
// ----------------------------------------------------------------------------
// Kalman tilt estimator divider
// Restoring fixed-point divider, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module kte_div #(
  parameter int WORD_BITS = kte_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = kte_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] n_i,
  input  logic signed [WORD_BITS-1:0] d_i,
  output logic signed [WORD_BITS-1:0] res_o,
  output kte_pkg::kte_unit_st_t       st_o
);
  import kte_pkg::*;

  localparam int NB = WORD_BITS + FRAC_BITS;
  localparam int CB = $clog2(NB + 1);
  localparam logic [NB-1:0] LIM_NEG = NB'(1) << (WORD_BITS - 1);
  localparam logic [NB-1:0] LIM_POS = LIM_NEG - NB'(1);
  localparam logic [CB-1:0] LAST_IT = CB'(NB - 1);

  logic                 busy_q, fin_q, neg_q;
  logic [CB-1:0]        cnt_q;
  logic [NB-1:0]        num_q, quo_q;
  logic [WORD_BITS-1:0] ud_q;
  logic [WORD_BITS:0]   rem_q, rem2;
  logic                 ge, over;
  logic [WORD_BITS-1:0] un, ud, qlo;

  assign un   = n_i[WORD_BITS-1] ? (~n_i + 1'b1) : n_i;
  assign ud   = d_i[WORD_BITS-1] ? (~d_i + 1'b1) : d_i;
  assign rem2 = {rem_q[WORD_BITS-1:0], num_q[NB-1]};
  assign ge   = rem2 >= {1'b0, ud_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
    end else if (fin_q) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else if (busy_q && cnt_q == LAST_IT) begin
      fin_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {un, {FRAC_BITS{1'b0}}} + NB'(ud >> 1);
      ud_q  <= ud;
      neg_q <= n_i[WORD_BITS-1] ^ d_i[WORD_BITS-1];
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (busy_q && !fin_q) begin
      rem_q <= ge ? (rem2 - {1'b0, ud_q}) : rem2;
      quo_q <= {quo_q[NB-2:0], ge};
      num_q <= num_q << 1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign over = quo_q > (neg_q ? LIM_NEG : LIM_POS);
  assign qlo  = quo_q[WORD_BITS-1:0];

  always_comb begin
    if (over) begin
      res_o = neg_q ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else begin
      res_o = neg_q ? (~qlo + 1'b1) : qlo;
    end
  end

  assign st_o.done = fin_q;
  assign st_o.sat  = over;

endmodule

// ----- rtl/kalman_tilt_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// Kalman tilt estimator unit
// Two-axis angle and rate Kalman filter run by a micro-sequencer over a
// shared saturating adder, limb multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one gyro and accel sample
//   pair per axis. Each accepted transaction runs one predict and correct
//   step and yields exactly one output transaction (out_valid_o /
//   out_stall_i) with both angles, both rates and a saturation flag.
//   The sequencer walks a 41-entry program of add, subtract, multiply and
//   divide steps. Multiply steps sum NL*NL limb partials (NL = 32-bit limbs
//   per word, 2 by default); divide steps yield WORD_BITS+FRAC_BITS quotient
//   bits, one quotient bit a cycle. in_stall_o is high from acceptance until
//   the result moves to the output register. A result held by out_stall_i
//   does not block the next input; that next step parks before its
//   write-out until the output frees up. Reset clears angles, rates and
//   off-diagonal covariance, sets the diagonal to 1.0 and loads the default
//   registers. Write configuration through cfg_we_i only while idle.
// ----------------------------------------------------------------------------
`include "kalman_tilt_estimator_unit_assert.svh"

module kalman_tilt_estimator_unit #(
  parameter int WORD_BITS = kte_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = kte_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kte_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [kte_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [WORD_BITS-1:0]         gyro_pitch_in_i,
  input  logic signed [WORD_BITS-1:0]         gyro_roll_in_i,
  input  logic signed [WORD_BITS-1:0]         accel_pitch_in_i,
  input  logic signed [WORD_BITS-1:0]         accel_roll_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [WORD_BITS-1:0]         pitch_estimate_o,
  output logic signed [WORD_BITS-1:0]         roll_estimate_o,
  output logic signed [WORD_BITS-1:0]         pitch_rate_estimate_o,
  output logic signed [WORD_BITS-1:0]         roll_rate_estimate_o,
  output logic                                overflow_flag_o
);
  import kte_pkg::*;

  localparam logic [63:0] WMAX64 = (64'd1 << (WORD_BITS - 1)) - 64'd1;
  localparam logic signed [63:0] WMAXS = signed'(WMAX64);
  localparam logic signed [63:0] WMINS = -WMAXS - 64'sd1;
  localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
  localparam logic [63:0] DIAG64 = (ONE64 > WMAX64) ? WMAX64 : ONE64;
  localparam logic [WORD_BITS-1:0] DIAG_RST = DIAG64[WORD_BITS-1:0];
  localparam logic [WORD_BITS-1:0] SAT_MAX = WMAX64[WORD_BITS-1:0];
  localparam logic [WORD_BITS-1:0] SAT_MIN = ~SAT_MAX;

  // Configuration registers
  logic [TS_BITS-1:0] ts_q;
  logic [QA_BITS-1:0] qa_q;
  logic [QC_BITS-1:0] qc_q;
  logic [QR_BITS-1:0] qr_q;
  logic [MN_BITS-1:0] mn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
      qa_q <= QA_RESET;
      qc_q <= QC_RESET;
      qr_q <= QR_RESET;
      mn_q <= MN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIME_STEP:  ts_q <= cfg_data_i[TS_BITS-1:0];
        CFG_Q_ANGLE:    qa_q <= cfg_data_i[QA_BITS-1:0];
        CFG_Q_CROSS:    qc_q <= cfg_data_i[QC_BITS-1:0];
        CFG_Q_RATE:     qr_q <= cfg_data_i[QR_BITS-1:0];
        CFG_MEAS_NOISE: mn_q <= cfg_data_i[MN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clip registers into the word range; only narrow words ever clip.
  logic [63:0] ts_ext, qa_ext, qr_ext, mn_ext;
  logic signed [63:0] qc_ext;
  logic ts_clip, qa_clip, qr_clip, mn_clip, qc_hi, qc_lo, cfg_clip;
  logic [WORD_BITS-1:0] dt_val, q00_val, q01_val, q11_val, r_val;

  assign ts_ext  = 64'(ts_q);
  assign qa_ext  = 64'(qa_q);
  assign qr_ext  = 64'(qr_q);
  assign mn_ext  = 64'(mn_q);
  assign qc_ext  = {{(64-QC_BITS){qc_q[QC_BITS-1]}}, qc_q};
  assign ts_clip = ts_ext > WMAX64;
  assign qa_clip = qa_ext > WMAX64;
  assign qr_clip = qr_ext > WMAX64;
  assign mn_clip = mn_ext > WMAX64;
  assign qc_hi   = qc_ext > WMAXS;
  assign qc_lo   = qc_ext < WMINS;
  assign cfg_clip = ts_clip | qa_clip | qr_clip | mn_clip | qc_hi | qc_lo;
  assign dt_val  = ts_clip ? SAT_MAX : ts_ext[WORD_BITS-1:0];
  assign q00_val = qa_clip ? SAT_MAX : qa_ext[WORD_BITS-1:0];
  assign q11_val = qr_clip ? SAT_MAX : qr_ext[WORD_BITS-1:0];
  assign r_val   = mn_clip ? SAT_MAX : mn_ext[WORD_BITS-1:0];
  assign q01_val = qc_hi ? SAT_MAX : (qc_lo ? SAT_MIN : qc_ext[WORD_BITS-1:0]);

  // Operand file: filter state plus per-step working values
  logic [WORD_BITS-1:0] dt_q, q00_q, q01_q, q11_q, r_q;
  logic [WORD_BITS-1:0] gp_q, gr_q, ap_q, ar_q;
  logic [WORD_BITS-1:0] ang0_q, ang1_q, rt0_q, rt1_q;
  logic [WORD_BITS-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [WORD_BITS-1:0] b_q, s_q, k0_q, k1_q, t_q, y_q;

  function automatic logic [WORD_BITS-1:0] rd(kte_opd_e c,
      logic [WORD_BITS-1:0] v0, logic [WORD_BITS-1:0] v1, logic [WORD_BITS-1:0] v2,
      logic [WORD_BITS-1:0] v3, logic [WORD_BITS-1:0] v4, logic [WORD_BITS-1:0] v5,
      logic [WORD_BITS-1:0] v6, logic [WORD_BITS-1:0] v7, logic [WORD_BITS-1:0] v8,
      logic [WORD_BITS-1:0] v9, logic [WORD_BITS-1:0] v10, logic [WORD_BITS-1:0] v11,
      logic [WORD_BITS-1:0] v12, logic [WORD_BITS-1:0] v13, logic [WORD_BITS-1:0] v14,
      logic [WORD_BITS-1:0] v15, logic [WORD_BITS-1:0] v16, logic [WORD_BITS-1:0] v17,
      logic [WORD_BITS-1:0] v18, logic [WORD_BITS-1:0] v19, logic [WORD_BITS-1:0] v20,
      logic [WORD_BITS-1:0] v21, logic [WORD_BITS-1:0] v22);
    logic [WORD_BITS-1:0] v;
    case (c)
      R_DT:   v = v0;
      R_Q00:  v = v1;
      R_Q01:  v = v2;
      R_Q11:  v = v3;
      R_R:    v = v4;
      R_GP:   v = v5;
      R_GR:   v = v6;
      R_AP:   v = v7;
      R_AR:   v = v8;
      R_ANG0: v = v9;
      R_ANG1: v = v10;
      R_RT0:  v = v11;
      R_RT1:  v = v12;
      R_P00:  v = v13;
      R_P01:  v = v14;
      R_P10:  v = v15;
      R_P11:  v = v16;
      R_B:    v = v17;
      R_S:    v = v18;
      R_K0:   v = v19;
      R_K1:   v = v20;
      R_T:    v = v21;
      R_Y:    v = v22;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sequencer state
  kte_state_e state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic [WORD_BITS-1:0] opa_q, opa_d, opb_q, opb_d;
  logic sat_q, sat_d;
  logic out_valid_q, out_valid_d;
  logic out_load;
  logic done_free;
  kte_uop_t uop;
  logic in_accept;
  logic wr_en;
  logic [WORD_BITS-1:0] wr_val;
  logic mul_start, div_start;
  logic signed [WORD_BITS-1:0] mul_res, div_res;
  kte_unit_st_t mul_st, div_st;
  logic [WORD_BITS:0] sum;
  logic sum_ovf;
  logic [WORD_BITS-1:0] sum_val;

  assign uop       = uop_at(step_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign done_free = (state_q == ST_DONE) && !(out_valid_q && out_stall_i);

  // Shared saturating adder: overflow shows as a sign mismatch of the extra bit
  always_comb begin
    if (uop.op == OP_SUB) begin
      sum = {opa_q[WORD_BITS-1], opa_q} - {opb_q[WORD_BITS-1], opb_q};
    end else begin
      sum = {opa_q[WORD_BITS-1], opa_q} + {opb_q[WORD_BITS-1], opb_q};
    end
  end
  assign sum_ovf = sum[WORD_BITS] ^ sum[WORD_BITS-1];
  assign sum_val = sum_ovf ? (sum[WORD_BITS] ? SAT_MIN : SAT_MAX) : sum[WORD_BITS-1:0];

  kte_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .res_o   (mul_res),
    .st_o    (mul_st)
  );

  kte_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (opa_q),
    .d_i     (opb_q),
    .res_o   (div_res),
    .st_o    (div_st)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    wr_en       = 1'b0;
    wr_val      = sum_val;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          step_d  = '0;
          sat_d   = cfg_clip;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        opa_d = rd(uop.a, dt_q, q00_q, q01_q, q11_q, r_q, gp_q, gr_q, ap_q, ar_q,
                   ang0_q, ang1_q, rt0_q, rt1_q, p00_q, p01_q, p10_q, p11_q,
                   b_q, s_q, k0_q, k1_q, t_q, y_q);
        opb_d = rd(uop.b, dt_q, q00_q, q01_q, q11_q, r_q, gp_q, gr_q, ap_q, ar_q,
                   ang0_q, ang1_q, rt0_q, rt1_q, p00_q, p01_q, p10_q, p11_q,
                   b_q, s_q, k0_q, k1_q, t_q, y_q);
        state_d = ST_RUN;
      end
      ST_RUN: begin
        case (uop.op)
          OP_MUL: begin
            mul_start = 1'b1;
            state_d   = ST_WAIT;
          end
          OP_DIV: begin
            if (opb_q == '0) begin
              // Zero innovation variance: skip the correction, flag it
              wr_en  = 1'b1;
              wr_val = '0;
              sat_d  = 1'b1;
            end else begin
              div_start = 1'b1;
              state_d   = ST_WAIT;
            end
          end
          default: begin
            wr_en = 1'b1;
            sat_d = sat_q | sum_ovf;
          end
        endcase
      end
      ST_WAIT: begin
        if (mul_st.done) begin
          wr_en  = 1'b1;
          wr_val = mul_res;
          sat_d  = sat_q | mul_st.sat;
        end else if (div_st.done) begin
          wr_en  = 1'b1;
          wr_val = div_res;
          sat_d  = sat_q | div_st.sat;
        end
      end
      ST_DONE: begin
        // Hold the finished step until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Advance the program after every write-back
    if (wr_en) begin
      if (step_q == LAST_STEP) begin
        state_d = ST_DONE;
      end else begin
        step_d  = step_q + 1'b1;
        state_d = ST_LOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  // Filter state: angles, rates and covariance survive between steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang0_q <= '0;
      ang1_q <= '0;
      rt0_q  <= '0;
      rt1_q  <= '0;
      p00_q  <= DIAG_RST;
      p11_q  <= DIAG_RST;
      p01_q  <= '0;
      p10_q  <= '0;
    end else if (wr_en) begin
      case (uop.dst)
        R_ANG0: ang0_q <= wr_val;
        R_ANG1: ang1_q <= wr_val;
        R_RT0:  rt0_q  <= wr_val;
        R_RT1:  rt1_q  <= wr_val;
        R_P00:  p00_q  <= wr_val;
        R_P01:  p01_q  <= wr_val;
        R_P10:  p10_q  <= wr_val;
        R_P11:  p11_q  <= wr_val;
        default: ;
      endcase
    end
  end

  // Working values and the sample captured at acceptance
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dt_q  <= dt_val;
      q00_q <= q00_val;
      q01_q <= q01_val;
      q11_q <= q11_val;
      r_q   <= r_val;
      gp_q  <= gyro_pitch_in_i;
      gr_q  <= gyro_roll_in_i;
      ap_q  <= accel_pitch_in_i;
      ar_q  <= accel_roll_in_i;
    end
    if (wr_en) begin
      case (uop.dst)
        R_B:  b_q  <= wr_val;
        R_S:  s_q  <= wr_val;
        R_K0: k0_q <= wr_val;
        R_K1: k1_q <= wr_val;
        R_T:  t_q  <= wr_val;
        R_Y:  y_q  <= wr_val;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pitch_estimate_o      <= ang0_q;
      roll_estimate_o       <= ang1_q;
      pitch_rate_estimate_o <= rt0_q;
      roll_rate_estimate_o  <= rt1_q;
      overflow_flag_o       <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `KTE_ASSERT_NOW(a_step_range, state_q != ST_IDLE, step_q <= LAST_STEP, "step out of range")
  `KTE_ASSERT_NOW(a_done_in_wait, mul_st.done || div_st.done, state_q == ST_WAIT, "stray done")
  `KTE_ASSERT_NEXT(a_done_loads_out, done_free, out_valid_q && !in_stall_o, "result not shown")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kalman tilt estimator regression bench
// Drives gyro and accel samples with random idling and backpressure, predicts
// every output transaction with a bit-true fixed-point filter model kept in a
// scoreboard class, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import kte_pkg::*;

  localparam int  WB = WORD_BITS_DEF;
  localparam int  FB = FRAC_BITS_DEF;
  localparam longint WMAX = (64'sd1 <<< (WB - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam longint ONE  = 64'sd1 <<< FB;
  localparam int  LIMIT_CYCLES = 6000000;
  localparam int  HOLD_CYCLES  = 3000;

  typedef logic signed [WB-1:0] word_t;

  typedef struct {
    word_t pitch;
    word_t roll;
    word_t pitch_rate;
    word_t roll_rate;
    logic  ovf;
  } estimate_t;

  // Filter model plus the queue of estimates still owed by the block.
  class tilt_scoreboard;
    longint dt, q00, q01, q11, r;
    longint angle[2], rate[2];
    longint p00, p01, p10, p11;
    bit     hit;
    int     errors;
    estimate_t owed[$];

    function new();
      dt = longint'(TS_RESET); q00 = longint'(QA_RESET);
      q01 = longint'(QC_RESET); q11 = longint'(QR_RESET); r = longint'(MN_RESET);
      angle = '{0, 0}; rate = '{0, 0};
      p00 = ONE; p11 = ONE; p01 = 0; p10 = 0;
      errors = 0;
    endfunction

    function void write_reg(kte_cfg_e idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        CFG_TIME_STEP:  dt  = longint'(d[TS_BITS-1:0]);
        CFG_Q_ANGLE:    q00 = longint'(d[QA_BITS-1:0]);
        CFG_Q_CROSS:    q01 = longint'($signed(d[QC_BITS-1:0]));
        CFG_Q_RATE:     q11 = longint'(d[QR_BITS-1:0]);
        CFG_MEAS_NOISE: r   = longint'(d[MN_BITS-1:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > WMAX) begin hit = 1; return WMAX; end
      if (v < WMIN) begin hit = 1; return WMIN; end
      return v;
    endfunction

    function longint add_s(longint a, longint b);
      return clip(a + b);
    endfunction

    function longint sub_s(longint a, longint b);
      return clip(a - b);
    endfunction

    // Apply sign to a magnitude and saturate.
    function longint signed_of(bit [127:0] m, bit neg);
      bit [127:0] lim;
      lim = neg ? 128'(WMAX) + 1 : 128'(WMAX);
      if (m > lim) begin
        hit = 1;
        return neg ? WMIN : WMAX;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function bit [127:0] mag(longint v);
      return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function longint mul_q(longint a, longint b);
      bit [127:0] p;
      p = mag(a) * mag(b);
      p = (p + (128'd1 << (FB - 1))) >> FB;
      return signed_of(p, (a < 0) != (b < 0));
    endfunction

    function longint div_q(longint n, longint d);
      bit [127:0] num;
      num = (mag(n) << FB) + (mag(d) >> 1);
      return signed_of(num / mag(d), (n < 0) != (d < 0));
    endfunction

    // Run one predict and correct step and queue the estimate it yields.
    function void note_sample(word_t gp, word_t gr, word_t ap, word_t ar);
      longint g[2], a[2];
      longint b, s, k0, k1, y, n00, n01, n10, n11;
      estimate_t e;
      g[0] = longint'(gp); g[1] = longint'(gr);
      a[0] = longint'(ap); a[1] = longint'(ar);
      hit = 0;
      for (int ax = 0; ax < 2; ax++) begin
        angle[ax] = add_s(angle[ax], mul_q(dt, rate[ax]));
        rate[ax]  = add_s(rate[ax], mul_q(dt, g[ax]));
      end
      b   = add_s(p01, mul_q(dt, p11));
      n00 = add_s(add_s(add_s(p00, mul_q(dt, p10)), mul_q(dt, b)), q00);
      n01 = add_s(b, q01);
      n10 = add_s(add_s(p10, mul_q(dt, p11)), q01);
      n11 = add_s(p11, q11);
      s = add_s(n00, r);
      if (s == 0) begin
        hit = 1; k0 = 0; k1 = 0;
      end else begin
        k0 = div_q(n00, s);
        k1 = div_q(n10, s);
      end
      for (int ax = 0; ax < 2; ax++) begin
        y = sub_s(a[ax], angle[ax]);
        angle[ax] = add_s(angle[ax], mul_q(k0, y));
        rate[ax]  = add_s(rate[ax], mul_q(k1, y));
      end
      p00 = sub_s(n00, mul_q(k0, n00));
      p01 = sub_s(n01, mul_q(k0, n01));
      p10 = sub_s(n10, mul_q(k1, n00));
      p11 = sub_s(n11, mul_q(k1, n01));
      e.pitch = word_t'(angle[0]); e.roll = word_t'(angle[1]);
      e.pitch_rate = word_t'(rate[0]); e.roll_rate = word_t'(rate[1]);
      e.ovf = hit;
      owed.push_back(e);
    endfunction

    task report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_estimate(estimate_t got);
      estimate_t want;
      if (owed.size() == 0) begin
        report_mismatch("unowed output pitch", got.pitch, '0);
        return;
      end
      want = owed.pop_front();
      if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
      if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
      if (got.pitch_rate !== want.pitch_rate)
        report_mismatch("pitch_rate", got.pitch_rate, want.pitch_rate);
      if (got.roll_rate !== want.roll_rate)
        report_mismatch("roll_rate", got.roll_rate, want.roll_rate);
      if (got.ovf !== want.ovf)
        report_mismatch("overflow", WB'(got.ovf), WB'(want.ovf));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i = '0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  word_t gyro_pitch_in_i = '0, gyro_roll_in_i = '0;
  word_t accel_pitch_in_i = '0, accel_roll_in_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t pitch_estimate_o, roll_estimate_o, pitch_rate_estimate_o, roll_rate_estimate_o;
  logic  overflow_flag_o;

  tilt_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_request = 0;
  int  cycle_count = 0;

  kalman_tilt_estimator_unit u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("kalman_tilt_estimator_unit regression: fail");
      $finish;
    end
  end

  // Result side: check every accepted output transaction.
  always @(posedge clk_i) begin
    estimate_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.pitch = pitch_estimate_o;
      got.roll = roll_estimate_o;
      got.pitch_rate = pitch_rate_estimate_o;
      got.roll_rate = roll_rate_estimate_o;
      got.ovf = overflow_flag_o;
      sb.check_estimate(got);
    end
  end

  // Receiver backpressure: random stalls, or one long hold when asked.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 0;
      end
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  // Mostly plausible sensor magnitudes, sometimes the full word.
  function automatic word_t rand_reading();
    word_t w;
    w = rand_word();
    if ($urandom_range(99) < 80) w = w >>> $urandom_range(6, 24);
    return w;
  endfunction

  // Offer one sample from a falling edge and hold it until accepted.
  task automatic send_sample(word_t gp, word_t gr, word_t ap, word_t ar);
    gyro_pitch_in_i = gp; gyro_roll_in_i = gr;
    accel_pitch_in_i = ap; accel_roll_in_i = ar;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(gp, gr, ap, ar);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Go idle on the input, then let the block drain.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(kte_cfg_e idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = d;
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_setting(longint dt, longint qa, longint qc, longint qr, longint mn);
    write_reg(CFG_TIME_STEP, CFG_DATA_BITS'(dt));
    write_reg(CFG_Q_ANGLE, CFG_DATA_BITS'(qa));
    write_reg(CFG_Q_CROSS, CFG_DATA_BITS'(qc));
    write_reg(CFG_Q_RATE, CFG_DATA_BITS'(qr));
    write_reg(CFG_MEAS_NOISE, CFG_DATA_BITS'(mn));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && send_idle_pct == 0 && recv_idle_pct == 0) hold_request = 1;
      if (i == count / 3) drain();
      send_sample(rand_reading(), rand_reading(), rand_reading(), rand_reading());
    end
  endtask

  initial begin
    longint qmax;
    qmax = (64'sd1 <<< 47) - 1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes at the reset defaults.
    send_sample(0, 0, 0, 0);
    send_sample(WMAX, WMAX, WMAX, WMAX);
    send_sample(WMIN, WMIN, WMIN, WMIN);
    send_sample(-1, 1, WMIN, WMAX);
    send_sample(WMAX, WMIN, -1, 0);
    send_sample(ONE, -ONE, ONE / 2, -ONE / 2);
    drain();

    // Directed: register extremes.
    write_setting(64'sd1 <<< 32, qmax, -(64'sd1 <<< 47), qmax, 1);
    send_sample(WMAX, WMIN, WMAX, WMIN);
    send_sample(ONE, ONE, -ONE, ONE);
    send_sample(0, 0, 0, 0);
    drain();
    write_setting(0, 0, qmax, 0, qmax);
    send_sample(WMIN, WMAX, WMIN, WMAX);
    send_sample(ONE, -ONE, ONE, -ONE);
    drain();
    // Drive the innovation variance to zero: P00 = 0 after predict, r = 0 not
    // allowed, so push P00 negative with a negative cross term at the reset time step.
    write_setting(TS_RESET, 0, -(ONE * 4), 0, 1);
    send_sample(ONE, ONE, ONE, ONE);
    send_sample(-ONE, ONE, 0, WMAX);
    drain();

    // Random phases; idling profile changes between them.
    send_idle_pct = 22; recv_idle_pct = 73;
    write_setting(TS_RESET, QA_RESET, QC_RESET, QR_RESET, MN_RESET);
    random_phase(650);
    drain();

    send_idle_pct = 73; recv_idle_pct = 22;
    write_setting($urandom_range(1, 32'hFFFF_FFFF) >> $urandom_range(0, 10),
                  {$urandom_range(0, 32'h7FFF), $urandom} >> $urandom_range(0, 20),
                  longint'(rand_word()) >>> $urandom_range(0, 20),
                  {$urandom_range(0, 32'h7FFF), $urandom} >> $urandom_range(0, 20),
                  1 + ({$urandom_range(0, 32'h7FFF), $urandom} >> $urandom_range(0, 16)));
    random_phase(650);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_setting(TS_RESET, QA_RESET, QC_RESET, QR_RESET, MN_RESET);
    random_phase(650);
    drain();

    repeat (400) @(negedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("kalman_tilt_estimator_unit regression: pass");
    end else begin
      $display("kalman_tilt_estimator_unit regression: fail");
    end
    $finish;
  end
endmodule
